// ===== design/ctu_pkg.sv =====
// ctu_pkg: shared types, constants and calendar tables for the civil time to
// unix seconds converter. No dependencies.
package ctu_pkg;

    localparam logic [13:0] YEAR_MIN      = 14'd1970;
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [4:0]  FEB_LEAP_DAY  = 5'd29;
    localparam logic [4:0]  HOUR_MAX      = 5'd23;
    localparam logic [5:0]  MINUTE_MAX    = 6'd59;
    localparam logic [5:0]  SECOND_MAX    = 6'd60;

    localparam logic [23:0] EPOCH_SHIFT   = 24'd719468;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [13:0] CENTURY       = 14'd100;

    // floor(x / 100) = (x * 5243) >> 19, exact for any 14-bit x
    localparam logic [26:0] DIV100_MUL    = 27'd5243;
    localparam int          DIV100_SHIFT  = 19;

    localparam int QUEUE_AW = 1;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        base_ok;   // all fields in range, day within common-year month length
        logic        feb29;     // fields in range, february 29, needs leap year
    } t_req;

    // month length of a common year, 0 for a month number outside 1..12
    function automatic logic [4:0] month_len_base(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days from march 1 to the first of month m
    function automatic logic [8:0] march_doy(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/ctu_front.sv =====
// ctu_front: request intake and field range classification.
// Depends on ctu_pkg.
module ctu_front import ctu_pkg::*; (
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    input  logic        i_q_full,
    output logic        o_push,
    output t_req        o_req
);

    logic w_year_ok;
    logic w_time_ok;
    logic w_day_ok;

    assign w_year_ok = (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX);
    assign w_time_ok = (i_hour <= HOUR_MAX) && (i_minute <= MINUTE_MAX) &&
                       (i_second <= SECOND_MAX);
    // month_len_base is zero for a bad month, so this also rejects it
    assign w_day_ok  = (i_day != 5'd0) && (i_day <= month_len_base(i_month));

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_req.year    = i_year;
        o_req.month   = i_month;
        o_req.day     = i_day;
        o_req.hour    = i_hour;
        o_req.minute  = i_minute;
        o_req.second  = i_second;
        o_req.base_ok = w_year_ok && w_time_ok && w_day_ok;
        o_req.feb29   = w_year_ok && w_time_ok && (i_month == MONTH_FEB) &&
                        (i_day == FEB_LEAP_DAY);
    end

endmodule

// ===== design/ctu_queue.sv =====
// ctu_queue: two-entry request queue between front and back.
// Depends on ctu_pkg.
module ctu_queue import ctu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_req o_head
);

    localparam int Depth = 1 << QUEUE_AW;

    t_req                r_mem [Depth];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_full       = (r_count == (QUEUE_AW+1)'(Depth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            // pointers wrap naturally, depth is a power of two
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// ===== design/ctu_back.sv =====
// ctu_back: four-stage arithmetic pipeline, day count, leap check, seconds.
// Depends on ctu_pkg.
module ctu_back import ctu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_req        i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_valid_res,
    output logic [37:0] o_epoch_secs
);

    logic w_en;

    // stage 1: shifted year, quotients by 100, day of year, time of day
    logic [13:0] n_s1_yy;
    logic [26:0] w_s1_pyy;
    logic [26:0] w_s1_py;
    logic [9:0]  w_s1_doy;
    logic        r_s1_v;
    logic [13:0] r_s1_yy;
    logic [13:0] r_s1_year;
    logic [7:0]  r_s1_qyy;
    logic [7:0]  r_s1_qy;
    logic [8:0]  r_s1_doy;
    logic [16:0] r_s1_tod;
    logic        r_s1_ok;
    logic        r_s1_feb29;

    // stage 2: day count and final validity
    logic [23:0] w_s2_sum;
    logic [13:0] w_s2_c100;
    logic        w_s2_leap;
    logic        w_s2_fields_ok;
    logic        r_s2_v;
    logic [21:0] r_s2_days;
    logic [16:0] r_s2_tod;
    logic        r_s2_ok;

    // stage 3: days to seconds
    logic        r_s3_v;
    logic [37:0] r_s3_prod;
    logic [16:0] r_s3_tod;
    logic        r_s3_ok;

    // stage 4: output register
    logic [37:0] n_secs;
    logic        r_out_v;
    logic        r_out_ok;
    logic [37:0] r_out_secs;

    assign w_en  = !r_out_v || i_out_ready;
    assign o_pop = i_head_valid && w_en;

    // january and february count as months of the previous year
    assign n_s1_yy  = (i_head.month <= MONTH_FEB) ? (i_head.year - 14'd1) : i_head.year;
    assign w_s1_pyy = 27'(n_s1_yy) * DIV100_MUL;
    assign w_s1_py  = 27'(i_head.year) * DIV100_MUL;
    assign w_s1_doy = 10'(march_doy(i_head.month)) + 10'(i_head.day) - 10'd1;

    assign w_s2_c100 = 14'(14'(r_s1_qy) * CENTURY);
    assign w_s2_leap = (r_s1_year[1:0] == 2'b00) &&
                       ((r_s1_year != w_s2_c100) || (r_s1_qy[1:0] == 2'b00));
    // 365*yy + yy/4 - yy/100 + yy/400 + doy - shift to 1970-01-01
    assign w_s2_sum = 24'(r_s1_yy) * 24'd365 + 24'(r_s1_yy >> 2) + 24'(r_s1_qyy >> 2)
                    + 24'(r_s1_doy) - 24'(r_s1_qyy) - EPOCH_SHIFT;
    assign w_s2_fields_ok = r_s1_ok || (r_s1_feb29 && w_s2_leap);

    assign n_secs = r_s3_prod + 38'(r_s3_tod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v  <= i_head_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_yy    <= n_s1_yy;
            r_s1_year  <= i_head.year;
            r_s1_qyy   <= 8'(w_s1_pyy >> DIV100_SHIFT);
            r_s1_qy    <= 8'(w_s1_py >> DIV100_SHIFT);
            r_s1_doy   <= w_s1_doy[8:0];
            r_s1_tod   <= 17'(i_head.hour) * SECS_PER_HOUR
                        + 17'(i_head.minute) * SECS_PER_MIN + 17'(i_head.second);
            r_s1_ok    <= i_head.base_ok;
            r_s1_feb29 <= i_head.feb29;

            r_s2_days  <= w_s2_sum[21:0];
            r_s2_tod   <= r_s1_tod;
            // the epoch instant itself is reported invalid
            r_s2_ok    <= w_s2_fields_ok && !((w_s2_sum[21:0] == 22'd0) && (r_s1_tod == 17'd0));

            r_s3_prod  <= 38'(r_s2_days) * 38'(SECS_PER_DAY);
            r_s3_tod   <= r_s2_tod;
            r_s3_ok    <= r_s2_ok;

            r_out_ok   <= r_s3_ok;
            r_out_secs <= r_s3_ok ? n_secs : '0;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_valid_res  = r_out_ok;
    assign o_epoch_secs = r_out_secs;

endmodule

// ===== design/civil_time_to_unix_seconds_unit.sv =====
// channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_year i_month i_day i_hour i_minute i_second
// out     | o_out_valid| i_out_ready | o_valid_res o_epoch_secs
//
// one request per cycle sustained while the output is ready; an accepted request
// passes through the queue and the four back pipeline stages (quotients and time
// of day, leap check and day sum, day-to-seconds multiply, output register)
// synchronous active-low reset clears queue and pipeline valid bits, no clearing pass
// an output stall freezes the back pipeline; the two-entry queue takes requests until
// it holds two, then intake stops
// depends on ctu_pkg, ctu_front, ctu_queue, ctu_back
module civil_time_to_unix_seconds_unit import ctu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_valid_res,
    output logic [37:0] o_epoch_secs
);

    logic w_push;
    t_req w_req;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_req w_head;

    ctu_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_year     (i_year),
        .i_month    (i_month),
        .i_day      (i_day),
        .i_hour     (i_hour),
        .i_minute   (i_minute),
        .i_second   (i_second),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_req      (w_req)
    );

    ctu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_req        (w_req),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    ctu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_valid_res  (o_valid_res),
        .o_epoch_secs (o_epoch_secs)
    );

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_epoch_secs == 38'd0))
        else $error("invalid result carries nonzero seconds");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_epoch_secs != 38'd0))
        else $error("valid result with zero seconds");

    a_valid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_epoch_secs <= 38'd253402300800))
        else $error("seconds beyond year 9999");

endmodule
